[sv/sequential_list_engine_unit_assert.svh]
// Assertion macros for the sequential list engine.
// No dependencies; included by the top level, which checks its own logic.
`ifndef SEQUENTIAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SLE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sle check failed");
// next-cycle implication
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sle check failed");
`else
`define SLE_ASSERT_NOW(label, clk, rst, ante, cons)
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[sv/sle_pkg.sv]
// Shared constants and types of the sequential list engine.
// No dependencies; used by sle_req_if, the cell, the chain and the top level.
package sle_pkg;

   localparam int CAPACITY = 128;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int LEN_W    = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_GET    = 2'd2,
      OP_LOCATE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic             ins_en;
      logic             del_en;
      logic             scan_en;
      logic             locate;
      logic [7:0]       slot;     // zero-based target position
      logic [7:0]       key;      // insert value or search value
      logic [LEN_W-1:0] length;
   } cell_ctl_type;

   // scan result handed from a cell to its left neighbor
   typedef struct packed {
      logic       hit;
      logic [7:0] data;
      logic [7:0] found;
   } scan_link_type;

endpackage

[sv/sle_req_if.sv]
// Command channel of the sequential list engine: valid/ready plus one command word.
// Depends on sle_pkg.
interface sle_req_if;
   logic                valid;
   logic                ready;
   sle_pkg::op_type     op;
   logic [7:0]          position;
   logic [7:0]          value;

   modport source (output valid, output op, output position, output value, input ready);
   modport sink   (input valid, input op, input position, input value, output ready);
endinterface

[sv/sle_rsp_if.sv]
// Result channel of the sequential list engine: valid/ready plus one result word.
// No package dependency.
interface sle_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [7:0] read_value;
   logic [7:0] found_position;
   logic [7:0] current_length;

   modport source (output valid, output status, output read_value,
                   output found_position, output current_length, input ready);
   modport sink   (input valid, input status, input read_value,
                   input found_position, input current_length, output ready);
endinterface

[sv/sle_cell.sv]
// One list slot: holds a byte, shifts with its neighbors, and forwards the scan result.
// Depends on sle_pkg.
module sle_cell (
   input  logic                       clock,
   input  sle_pkg::cell_ctl_type      ctl,
   input  logic [sle_pkg::IDX_W-1:0]  index,
   input  logic [7:0]                 left_data,
   input  logic [7:0]                 right_data,
   input  sle_pkg::scan_link_type     right_link,
   output logic [7:0]                 data,
   output sle_pkg::scan_link_type     link
);
   import sle_pkg::*;

   logic [7:0]    data_ff, data_in;
   scan_link_type link_ff, link_in;
   logic [31:0]   index32, slot32, found32;
   logic          at_slot, in_list, hit;

   always_comb begin
      index32 = 32'(index);
      slot32  = 32'(ctl.slot);
      found32 = index32 + 32'd1;
      at_slot = (index32 == slot32);
      in_list = (index32 < 32'(ctl.length));

      data_in = data_ff;
      if (ctl.ins_en) begin
         if (at_slot) begin
            data_in = ctl.key;
         end else if (index32 > slot32) begin
            data_in = left_data;
         end
      end else if (ctl.del_en && (index32 >= slot32)) begin
         data_in = right_data;
      end

      // locate matches on value, get/delete on position
      hit = ctl.locate ? (in_list && (data_ff == ctl.key)) : at_slot;

      link_in = link_ff;
      if (ctl.scan_en) begin
         link_in.hit   = hit | right_link.hit;
         link_in.data  = hit ? data_ff : right_link.data;
         link_in.found = hit ? found32[7:0] : right_link.found;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      link_ff <= link_in;
   end

   assign data = data_ff;
   assign link = link_ff;

endmodule

[sv/sle_chain.sv]
// Row of CAPACITY list cells wired neighbor to neighbor; cell 0 is the head.
// Depends on sle_pkg and sle_cell.
module sle_chain (
   input  logic                   clock,
   input  sle_pkg::cell_ctl_type  ctl,
   output sle_pkg::scan_link_type head
);
   import sle_pkg::*;

   logic [7:0]    data_w [CAPACITY];
   scan_link_type link_w [CAPACITY];

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [7:0]    left_d;
      logic [7:0]    right_d;
      scan_link_type right_l;

      if (g == 0) begin : g_first
         assign left_d = 8'd0;
      end else begin : g_mid
         assign left_d = data_w[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_d = 8'd0;
         assign right_l = '0;
      end else begin : g_inner
         assign right_d = data_w[g+1];
         assign right_l = link_w[g+1];
      end

      sle_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .index      (IDX_W'(g)),
         .left_data  (left_d),
         .right_data (right_d),
         .right_link (right_l),
         .data       (data_w[g]),
         .link       (link_w[g])
      );
   end

   assign head = link_w[0];

endmodule

[sv/sequential_list_engine_unit.sv]
// Sequential list engine: an ordered list of up to CAPACITY bytes with insert, delete,
// get and locate commands. Depends on sle_pkg, sle_req_if, sle_rsp_if and sle_chain.
//
// The list lives in a row of cells, one byte each. Insert and delete shift every cell
// at once at commit, so an insert, accepted or rejected, goes from acceptance straight
// to commit without a scan. Get, delete and locate always scan first, even when the
// position is out of range: a scan result moves one cell per cycle toward the head,
// so the scan covers the whole cell chain. One command is in flight at a time; the
// next word is accepted as soon as the current result sits in the output register,
// even if the sink has not taken it yet, and a finished command then waits until
// that register frees up. Errors (position out of range, insert into a full list)
// report status 1 and leave the list untouched. Lengths and positions are reported
// modulo 256.
`include "sequential_list_engine_unit_assert.svh"

module sequential_list_engine_unit (
   input  logic      clock,
   input  logic      reset,
   sle_req_if.sink   req_chan,
   sle_rsp_if.source rsp_chan
);
   import sle_pkg::*;

   // sequencer
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] count_ff, count_in;

   // latched command word
   op_type     op_ff, op_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] value_ff, value_in;

   // list length
   logic [LEN_W-1:0] len_ff, len_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       status_ff, status_in;
   logic [7:0] read_ff, read_in;
   logic [7:0] found_ff, found_in;
   logic [7:0] length_ff, length_in;

   logic          fire;        // result committed this cycle
   logic          scan_en;
   logic          insert_ok, pos_ok, ins_en, del_en;
   logic [31:0]   len32, pos32, len_after32;
   cell_ctl_type  ctl;
   scan_link_type head;

   // range checks against the current length
   always_comb begin
      len32     = 32'(len_ff);
      pos32     = 32'(pos_ff);
      insert_ok = (pos32 != 32'd0) && (pos32 <= len32 + 32'd1) && (len32 < CAPACITY);
      pos_ok    = (pos32 != 32'd0) && (pos32 <= len32);
   end

   // sequencer: accept, scan the chain when needed, then commit
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      op_in            = op_ff;
      pos_in           = pos_ff;
      value_in         = value_ff;
      req_chan.ready   = 1'b0;
      scan_en          = 1'b0;
      fire             = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               op_in    = req_chan.op;
               pos_in   = req_chan.position;
               value_in = req_chan.value;
               count_in = IDX_W'(CAPACITY - 1);
               state_in = (req_chan.op == OP_INSERT) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_en = 1'b1;
            if (count_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               count_in = count_ff - IDX_W'(1);
            end
         end
         ST_FINISH: begin
            // wait for a free output register
            if (!rsp_valid_ff || rsp_chan.ready) begin
               fire     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // list update happens only at commit
   always_comb begin
      ins_en = fire && (op_ff == OP_INSERT) && insert_ok;
      del_en = fire && (op_ff == OP_DELETE) && pos_ok;
      len_in = len_ff;
      if (ins_en) begin
         len_in = len_ff + LEN_W'(1);
      end else if (del_en) begin
         len_in = len_ff - LEN_W'(1);
      end
      len_after32 = 32'(len_in);
   end

   // broadcast to the cells
   always_comb begin
      ctl.ins_en  = ins_en;
      ctl.del_en  = del_en;
      ctl.scan_en = scan_en;
      ctl.locate  = (op_ff == OP_LOCATE);
      ctl.slot    = pos_ff - 8'd1;
      ctl.key     = value_ff;
      ctl.length  = len_ff;
   end

   sle_chain u_chain (
      .clock (clock),
      .ctl   (ctl),
      .head  (head)
   );

   // result word; head still holds the pre-shift element during commit
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      read_in      = read_ff;
      found_in     = found_ff;
      length_in    = length_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         read_in      = 8'd0;
         found_in     = 8'd0;
         length_in    = len_after32[7:0];
         unique case (op_ff)
            OP_INSERT: status_in = !insert_ok;
            OP_DELETE, OP_GET: begin
               status_in = !pos_ok;
               read_in   = pos_ok ? head.data : 8'd0;
            end
            OP_LOCATE: begin
               status_in = 1'b0;
               found_in  = head.hit ? head.found : 8'd0;
            end
         endcase
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff  <= count_in;
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      read_ff   <= read_in;
      found_ff  <= found_in;
      length_ff <= length_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.read_value     = read_ff;
   assign rsp_chan.found_position = found_ff;
   assign rsp_chan.current_length = length_ff;

   `SLE_ASSERT_NOW(a_len_cap, clock, reset, 1'b1, 32'(len_ff) <= CAPACITY)
   `SLE_ASSERT_NEXT(a_ins_grow, clock, reset, ins_en, len_ff == $past(len_ff) + LEN_W'(1))
   `SLE_ASSERT_NEXT(a_del_shrink, clock, reset, del_en, len_ff == $past(len_ff) - LEN_W'(1))
   `SLE_ASSERT_NEXT(a_len_hold, clock, reset, !ins_en && !del_en, $stable(len_ff))

endmodule

[test/sequential_list_engine_unit_tb.sv]
// Testbench for sequential_list_engine_unit: a directed table, then fill/drain random traffic.
// Every result word is checked, against the row's expected word or an in-bench list predictor.
// Depends on sle_pkg, sle_req_if, sle_rsp_if and the unit itself.
module sequential_list_engine_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sle_pkg::*;

   localparam int RANDOM_ITEMS = 830;
   localparam int HOLD_AT      = 300;   // result count at which the sink goes quiet
   localparam int HOLD_CYCLES  = 500;   // long sink stall, backs up into the cmd side

   typedef struct packed {
      op_type     op;
      logic [7:0] position;
      logic [7:0] value;
   } list_cmd_t;

   typedef struct packed {
      logic       status;
      logic [7:0] read_value;
      logic [7:0] found_position;
      logic [7:0] current_length;
   } list_result_t;

   // directed row: want is only meaningful when typed is set
   typedef struct {
      op_type       op;
      logic [7:0]   position;
      logic [7:0]   value;
      bit           typed;
      list_result_t want;
   } dir_row_t;

   logic clock = 1'b0;
   logic reset;

   sle_req_if req_bus ();
   sle_rsp_if rsp_bus ();

   sequential_list_engine_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state: mirror of the list contents and its length
   logic [7:0]   list_bytes [CAPACITY];
   int           list_len = 0;
   list_result_t pending_results [$];
   int           mismatches = 0;
   int           sent_count = 0;

   // Directed walk. Empty-list errors, bad positions (0, past end, 255), append, head
   // insert, duplicate values where locate must report the lowest position, and delete
   // returning the removed byte. Rows with typed = 0 go through the predictor.
   dir_row_t dir_rows [24] = '{
      '{OP_GET,    8'd1,   8'h00, 1'b1, {1'b1, 8'h00, 8'd0, 8'd0}},  // get on empty
      '{OP_DELETE, 8'd1,   8'h00, 1'b1, {1'b1, 8'h00, 8'd0, 8'd0}},  // delete on empty
      '{OP_LOCATE, 8'd0,   8'h00, 1'b1, {1'b0, 8'h00, 8'd0, 8'd0}},  // locate on empty
      '{OP_INSERT, 8'd0,   8'hAA, 1'b1, {1'b1, 8'h00, 8'd0, 8'd0}},  // position zero
      '{OP_INSERT, 8'd2,   8'hAA, 1'b1, {1'b1, 8'h00, 8'd0, 8'd0}},  // past the end
      '{OP_INSERT, 8'd1,   8'hFF, 1'b1, {1'b0, 8'h00, 8'd0, 8'd1}},
      '{OP_INSERT, 8'd1,   8'h00, 1'b1, {1'b0, 8'h00, 8'd0, 8'd2}},  // head insert
      '{OP_INSERT, 8'd3,   8'h80, 1'b1, {1'b0, 8'h00, 8'd0, 8'd3}},  // append
      '{OP_INSERT, 8'd2,   8'h7F, 1'b1, {1'b0, 8'h00, 8'd0, 8'd4}},  // 00 7F FF 80
      '{OP_GET,    8'd1,   8'h00, 1'b0, '0},
      '{OP_GET,    8'd4,   8'h00, 1'b0, '0},
      '{OP_GET,    8'd5,   8'h00, 1'b1, {1'b1, 8'h00, 8'd0, 8'd4}},
      '{OP_GET,    8'd255, 8'hFF, 1'b1, {1'b1, 8'h00, 8'd0, 8'd4}},
      '{OP_LOCATE, 8'd0,   8'hFF, 1'b1, {1'b0, 8'h00, 8'd3, 8'd4}},
      '{OP_LOCATE, 8'd9,   8'h55, 1'b1, {1'b0, 8'h00, 8'd0, 8'd4}},  // absent value
      '{OP_INSERT, 8'd255, 8'h01, 1'b1, {1'b1, 8'h00, 8'd0, 8'd4}},
      '{OP_INSERT, 8'd5,   8'hFF, 1'b1, {1'b0, 8'h00, 8'd0, 8'd5}},  // duplicate FF
      '{OP_LOCATE, 8'd0,   8'hFF, 1'b0, '0},                         // lowest of two
      '{OP_DELETE, 8'd6,   8'h00, 1'b1, {1'b1, 8'h00, 8'd0, 8'd5}},
      '{OP_DELETE, 8'd3,   8'h00, 1'b1, {1'b0, 8'hFF, 8'd0, 8'd4}},  // 00 7F 80 FF
      '{OP_LOCATE, 8'd0,   8'hFF, 1'b0, '0},
      '{OP_DELETE, 8'd0,   8'h00, 1'b1, {1'b1, 8'h00, 8'd0, 8'd4}},
      '{OP_DELETE, 8'd1,   8'h00, 1'b1, {1'b0, 8'h00, 8'd0, 8'd3}},  // 7F 80 FF
      '{OP_GET,    8'd1,   8'hFF, 1'b0, '0}                          // value is a don't-care
   };

   // Apply one accepted command to the mirrored list and return its result word.
   function automatic list_result_t apply_to_list(input list_cmd_t c);
      list_result_t res;
      int           pos;
      res = '0;
      pos = int'(c.position);
      case (c.op)
         OP_INSERT: begin
            if (pos < 1 || pos > list_len + 1 || list_len >= CAPACITY) begin
               res.status = 1'b1;
            end else begin
               for (int j = list_len; j > pos - 1; j--) list_bytes[j] = list_bytes[j - 1];
               list_bytes[pos - 1] = c.value;
               list_len++;
            end
         end
         OP_DELETE: begin
            if (pos < 1 || pos > list_len) begin
               res.status = 1'b1;
            end else begin
               res.read_value = list_bytes[pos - 1];
               for (int j = pos; j < list_len; j++) list_bytes[j - 1] = list_bytes[j];
               list_len--;
            end
         end
         OP_GET: begin
            if (pos < 1 || pos > list_len) res.status = 1'b1;
            else res.read_value = list_bytes[pos - 1];
         end
         default: begin
            // scan from the tail so the lowest matching position wins
            for (int j = list_len - 1; j >= 0; j--)
               if (list_bytes[j] == c.value) res.found_position = 8'(j + 1);
         end
      endcase
      res.current_length = 8'(list_len);
      return res;
   endfunction

   // Random command. Mostly well-formed: positions near the valid window, with the
   // boundaries and one-past-the-end favored; a fill phase leans on insert, a drain
   // phase on delete. A few words are plain noise over the full field ranges.
   function automatic list_cmd_t random_cmd(input bit filling);
      list_cmd_t c;
      int        pick;
      int        top;
      c.op       = op_type'($urandom_range(0, 3));
      c.position = 8'($urandom_range(0, 255));
      c.value    = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 8) return c;
      pick = $urandom_range(0, 99);
      if (pick < 65) c.op = filling ? OP_INSERT : OP_DELETE;
      else if (pick < 75) c.op = filling ? OP_DELETE : OP_INSERT;
      else if (pick < 88) c.op = OP_GET;
      else c.op = OP_LOCATE;
      top = (c.op == OP_INSERT) ? list_len + 1 : list_len;
      if (top == 0) begin
         c.position = 8'd1;
      end else begin
         case ($urandom_range(0, 5))
            0: c.position = 8'd1;
            1: c.position = 8'(top);
            2: c.position = 8'(top + 1);
            default: c.position = 8'($urandom_range(1, top));
         endcase
      end
      // half the searches look for a byte that is really in the list
      if (c.op == OP_LOCATE && list_len > 0 && $urandom_range(0, 1) == 1)
         c.value = list_bytes[$urandom_range(0, list_len - 1)];
      return c;
   endfunction

   // Idle cycles before a word; every fourth block of 48 words runs back to back.
   function automatic int draw_gap(input int n);
      if ((n / 48) % 4 == 3) return 0;
      return $urandom_range(0, 16);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s mismatch, got %0h want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Offer one command word from a falling edge; returns at the falling edge after
   // it was taken. valid stays high across back-to-back words.
   task automatic send_cmd(input list_cmd_t c, input bit typed, input list_result_t want);
      int           gap;
      list_result_t got;
      gap = draw_gap(sent_count);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.op       <= c.op;
      req_bus.position <= c.position;
      req_bus.value    <= c.value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // word taken at this edge: update the mirror and queue what must come back
      got = apply_to_list(c);
      pending_results.push_back(typed ? want : got);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic check_result();
      list_result_t want;
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected result word, status", int'(rsp_bus.status), 0);
      end else begin
         want = pending_results.pop_front();
         if (rsp_bus.status !== want.status)
            report_mismatch("status", int'(rsp_bus.status), int'(want.status));
         if (rsp_bus.read_value !== want.read_value)
            report_mismatch("read_value", int'(rsp_bus.read_value),
                            int'(want.read_value));
         if (rsp_bus.found_position !== want.found_position)
            report_mismatch("found_position", int'(rsp_bus.found_position),
                            int'(want.found_position));
         if (rsp_bus.current_length !== want.current_length)
            report_mismatch("current_length", int'(rsp_bus.current_length),
                            int'(want.current_length));
      end
   endtask

   // Result side: random stalls per word, one long hold-off mid-run so the single
   // command slot and the output register fill and the command side backs up.
   initial begin : result_sink
      int stall;
      int taken;
      taken = 0;
      rsp_bus.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = (taken == HOLD_AT) ? HOLD_CYCLES : draw_gap(taken);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         check_result();
         taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      list_cmd_t c;
      bit        filling;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.op       <= OP_INSERT;
      req_bus.position <= 8'd0;
      req_bus.value    <= 8'd0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         c.op       = dir_rows[i].op;
         c.position = dir_rows[i].position;
         c.value    = dir_rows[i].value;
         send_cmd(c, dir_rows[i].typed, dir_rows[i].want);
      end

      // fill to capacity (and bang on the full list for a while), then drain to empty
      filling = 1'b1;
      repeat (RANDOM_ITEMS) begin
         c = random_cmd(filling);
         send_cmd(c, 1'b0, '0);
         if (filling && list_len == CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
         else if (!filling && list_len == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
      end
      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      // give a stray word time to show up after the last result
      repeat (CAPACITY + 16) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // worst case is well under 2 ms of simulated time
   initial begin : watchdog
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
